[src/tpcr_pkg.sv]
`timescale 1ns / 1ps

package tpcr_pkg;

  // Packet counter width (wrapping packet numbers).
  localparam int CNT_W = 32;
  // Output packet number width.
  localparam int SEG_W = 32;
  // PCR value width: 33-bit base * 300 + 9-bit extension.
  localparam int PCR_W = 42;
  // Interval field width and its saturation value.
  localparam int IV_W = 31;
  localparam logic [IV_W-1:0] INTERVAL_MAX = {IV_W{1'b1}};
  // Dividend: dPCR times a 3-bit datagram size.
  localparam int PPD_W = 3;
  localparam int NUM_W = PCR_W + PPD_W;
  // Divisor: dPackets times 27.
  localparam int DEN_W = CNT_W + 5;
  localparam int STEP_W = $clog2(NUM_W);
  // Reset datagram size.
  localparam logic [PPD_W-1:0] PPD_RESET = 3'd7;
  // Adaptation field control codes with an adaptation field present.
  localparam logic [1:0] AFC_ADAPT_ONLY = 2'b10;
  localparam logic [1:0] AFC_ADAPT_PAYLOAD = 2'b11;
  // PCR flag position in the adaptation flags byte.
  localparam int PCR_FLAG_BIT = 4;
  // Job queue depth between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [1:0]  adaptation_control;
    logic [7:0]  adaptation_length;
    logic [7:0]  adaptation_flags;
    logic [47:0] pcr_bytes;
  } in_item_t;

  typedef struct packed {
    logic [SEG_W-1:0] segment_end_packet;
    logic [IV_W-1:0]  datagram_interval_us;
    logic             pcr_not_forward;
  } result_t;

  // One closed segment handed from front to back.
  typedef struct packed {
    logic [SEG_W-1:0] pkt;
    logic [PCR_W-1:0] dpcr;
    logic [CNT_W-1:0] dpk;
    logic             not_fwd;
  } job_t;

  // Queue handshake toward the back part.
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

[src/tpcr_front.sv]
`timescale 1ns / 1ps

module tpcr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  tpcr_pkg::in_item_t item,
  output logic              q_push,
  output tpcr_pkg::job_t    q_job,
  input  logic              q_full
);

  logic [tpcr_pkg::CNT_W-1:0] counter;
  logic                       s_valid;
  logic                       s_has;
  logic [tpcr_pkg::PCR_W-1:0] s_pcr;
  logic [tpcr_pkg::CNT_W-1:0] s_cnt;
  logic [tpcr_pkg::PCR_W-1:0] ref_pcr;
  logic [tpcr_pkg::CNT_W-1:0] ref_pkt;

  logic                       accept;
  logic                       has_pcr;
  logic [tpcr_pkg::PCR_W-1:0] base_w;
  logic [tpcr_pkg::PCR_W-1:0] pcr_value;
  logic                       ref_held;
  logic                       s_go;

  // Classify: adaptation field present, nonzero length, PCR flag set.
  assign has_pcr = ((item.adaptation_control == tpcr_pkg::AFC_ADAPT_ONLY) ||
                    (item.adaptation_control == tpcr_pkg::AFC_ADAPT_PAYLOAD)) &&
                   (item.adaptation_length != 8'd0) &&
                   item.adaptation_flags[tpcr_pkg::PCR_FLAG_BIT];

  // PCR = base * 300 + extension, 300 = 256 + 32 + 8 + 4.
  assign base_w = tpcr_pkg::PCR_W'(item.pcr_bytes[47:15]);
  assign pcr_value = ((base_w << 8) + (base_w << 5)) + ((base_w << 3) + (base_w << 2))
                   + tpcr_pkg::PCR_W'(item.pcr_bytes[8:0]);

  assign ref_held = (ref_pcr != '0);
  // Hold the stage only when it closes a segment and the queue has no room.
  assign s_go   = s_valid && !(s_has && ref_held && q_full);
  assign full   = s_valid && !s_go;
  assign accept = push && !full;

  // Build the job for a closed segment.
  assign q_push        = s_valid && s_has && ref_held && !q_full;
  assign q_job.pkt     = tpcr_pkg::SEG_W'(s_cnt);
  assign q_job.dpcr    = s_pcr - ref_pcr;
  assign q_job.dpk     = s_cnt - ref_pkt;
  assign q_job.not_fwd = (s_pcr <= ref_pcr);

  // Count packets and register the classified beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      s_valid <= 1'b0;
    end else if (accept) begin
      counter <= counter + 1'b1;
      s_valid <= 1'b1;
    end else if (s_go) begin
      s_valid <= 1'b0;
    end
    if (accept) begin
      s_has <= has_pcr;
      s_pcr <= pcr_value;
      s_cnt <= counter + 1'b1;
    end
  end

  // Replace the reference on every PCR packet leaving the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_pcr <= '0;
      ref_pkt <= '0;
    end else if (s_go && s_has) begin
      ref_pcr <= s_pcr;
      ref_pkt <= s_cnt;
    end
  end

endmodule

[src/tpcr_queue.sv]
`timescale 1ns / 1ps

module tpcr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  tpcr_pkg::job_t      wr_job,
  input  logic                rd,
  output tpcr_pkg::job_t      rd_job,
  output tpcr_pkg::q_status_t status
);

  tpcr_pkg::job_t                 slots [tpcr_pkg::Q_DEPTH];
  logic [tpcr_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [tpcr_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [tpcr_pkg::Q_PTR_W:0]     count;
  logic                           do_wr;
  logic                           do_rd;

  assign status.valid = (count != '0);
  assign status.full  = (count == (tpcr_pkg::Q_PTR_W + 1)'(tpcr_pkg::Q_DEPTH));
  assign do_wr  = wr && !status.full;
  assign do_rd  = rd && status.valid;
  assign rd_job = slots[rd_ptr];

  // Advance pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  // Store the incoming job.
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_job;
  end

endmodule

[src/tpcr_back.sv]
`timescale 1ns / 1ps

module tpcr_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic [tpcr_pkg::PPD_W-1:0] cfg_data,
  input  tpcr_pkg::q_status_t        q_status,
  input  tpcr_pkg::job_t             q_job,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output tpcr_pkg::result_t          result
);

  typedef enum logic [1:0] {IDLE, DIV, DONE} state_t;

  state_t                         state;
  logic [tpcr_pkg::PPD_W-1:0]     ppd;
  logic [tpcr_pkg::STEP_W-1:0]    step;
  logic [tpcr_pkg::NUM_W-1:0]     num;
  logic [tpcr_pkg::DEN_W-1:0]     den;
  logic [tpcr_pkg::DEN_W-1:0]     rem;
  logic [tpcr_pkg::SEG_W-1:0]     pkt;
  logic                           nf;
  logic                           dz;
  logic                           out_valid;

  logic [tpcr_pkg::NUM_W-1:0]     x_w;
  logic [tpcr_pkg::NUM_W-1:0]     x_load;
  logic [tpcr_pkg::DEN_W-1:0]     d_w;
  logic [tpcr_pkg::DEN_W-1:0]     d_load;
  logic [tpcr_pkg::DEN_W:0]       shifted;
  logic [tpcr_pkg::DEN_W:0]       diff;
  logic                           ge;
  logic                           out_free;
  logic                           sat;
  logic [tpcr_pkg::IV_W-1:0]      interval;

  // Dividend dPCR * N and divisor dPackets * 27 (27 = 16 + 8 + 2 + 1).
  assign x_w    = tpcr_pkg::NUM_W'(q_job.dpcr);
  assign x_load = (ppd[0] ? x_w : '0) + (ppd[1] ? (x_w << 1) : '0)
                + (ppd[2] ? (x_w << 2) : '0);
  assign d_w    = tpcr_pkg::DEN_W'(q_job.dpk);
  assign d_load = ((d_w << 4) + (d_w << 3)) + ((d_w << 1) + d_w);

  // One restoring division step per cycle.
  assign shifted = {rem, num[tpcr_pkg::NUM_W-1]};
  assign diff    = shifted - {1'b0, den};
  assign ge      = (shifted >= {1'b0, den});

  assign q_pop    = (state == IDLE) && q_status.valid;
  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  // Saturate the quotient into the interval field; a non-forward PCR gives zero, a zero packet distance the maximum.
  assign sat      = |num[tpcr_pkg::NUM_W-1:tpcr_pkg::IV_W];
  assign interval = nf  ? '0 :
                    dz  ? tpcr_pkg::INTERVAL_MAX :
                    sat ? tpcr_pkg::INTERVAL_MAX : num[tpcr_pkg::IV_W-1:0];

  // Datagram size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ppd <= tpcr_pkg::PPD_RESET;
    end else if (cfg_valid) begin
      ppd <= cfg_data;
    end
  end

  // Sequence load, divide and hand-off to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop a popped beat unless a new one replaces it this cycle.
      if (pop && out_valid && (state != DONE)) out_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (q_status.valid) begin
            pkt  <= q_job.pkt;
            nf   <= q_job.not_fwd;
            dz   <= (q_job.dpk == '0);
            num  <= x_load;
            den  <= d_load;
            rem  <= '0;
            step <= '0;
            if (q_job.not_fwd || (q_job.dpk == '0)) state <= DONE;
            else state <= DIV;
          end
        end
        DIV: begin
          rem  <= ge ? diff[tpcr_pkg::DEN_W-1:0] : shifted[tpcr_pkg::DEN_W-1:0];
          num  <= {num[tpcr_pkg::NUM_W-2:0], ge};
          step <= step + 1'b1;
          if (step == tpcr_pkg::STEP_W'(tpcr_pkg::NUM_W - 1)) state <= DONE;
        end
        DONE: begin
          if (out_free) begin
            result.segment_end_packet   <= pkt;
            result.datagram_interval_us <= interval;
            result.pcr_not_forward      <= nf;
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[src/ts_pcr_pacing_interval.sv]
`timescale 1ns / 1ps

// PCR-based pacing: packets are numbered from 1; each PCR that follows a
// nonzero reference PCR closes a segment and yields one result with the closing
// packet number and floor(dPCR * N / (dPackets * 27)) microseconds between
// datagrams, saturated. Input beats are taken one per cycle, registered in the
// front stage and then written to the four-entry job queue, while it has room.
// In the back part each closed segment is loaded, runs through 45 steps of a
// bit-serial restoring divider (one quotient bit per cycle) and is moved into
// the result register once that is free; a non-forward PCR or a zero packet
// distance skips the divider; the next job is loaded only after that move.
// The datagram size register, written via cfg_valid/cfg_data, is always ready.
module ts_pcr_pacing_interval (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  tpcr_pkg::in_item_t         item,
  output logic                       empty,
  input  logic                       pop,
  output tpcr_pkg::result_t          result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tpcr_pkg::PPD_W-1:0] cfg_data
);

  logic                 q_push;
  logic                 q_pop;
  tpcr_pkg::job_t       q_in;
  tpcr_pkg::job_t       q_out;
  tpcr_pkg::q_status_t  q_status;

  assign cfg_ready = 1'b1;

  tpcr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_push (q_push),
    .q_job  (q_in),
    .q_full (q_status.full)
  );

  tpcr_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_push),
    .wr_job (q_in),
    .rd     (q_pop),
    .rd_job (q_out),
    .status (q_status)
  );

  tpcr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .q_job     (q_out),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

[src/tpcr_checker.sv]
`timescale 1ns / 1ps

module tpcr_checker (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input tpcr_pkg::result_t result
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown after reset");

  // Reset frees the input side.
  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");

  // A non-forward PCR always carries a zero interval.
  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.pcr_not_forward) |-> (result.datagram_interval_us == '0))
    else $error("non-forward PCR with nonzero interval");

  // A waiting result holds until popped.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed");

endmodule

bind ts_pcr_pacing_interval tpcr_checker u_tpcr_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_GUARD = 20000;
  localparam int CHUNK_ITEMS = 250;
  localparam int CHUNKS = 7;
  localparam int HOLD_CYCLES = 300;
  localparam int BURST_ITEMS = 40;
  localparam longint unsigned PCR_CEILING = 64'd2576980377000;

  // One directed beat, with its outcome pinned where it is obvious.
  typedef struct packed {
    tpcr_pkg::in_item_t pkt;
    logic               pinned;
    logic               yields;
    tpcr_pkg::result_t  outcome;
  } dir_row_t;

  localparam dir_row_t DIRECTED [20] = '{
    // zero PCR after reset only becomes the reference
    '{'{2'd2, 8'd1, 8'h10, 48'h0}, 1'b1, 1'b0, '{32'd0, 31'd0, 1'b0}},
    // zero reference counts as none: this one becomes the reference too
    '{'{2'd3, 8'd255, 8'hFF, 48'h8000}, 1'b1, 1'b0, '{32'd0, 31'd0, 1'b0}},
    // no adaptation field, zero length, flag clear
    '{'{2'd0, 8'd1, 8'h10, 48'h8000}, 1'b1, 1'b0, '{32'd0, 31'd0, 1'b0}},
    '{'{2'd1, 8'd255, 8'hFF, 48'hFFFF_FFFF_FFFF}, 1'b1, 1'b0, '{32'd0, 31'd0, 1'b0}},
    '{'{2'd2, 8'd0, 8'h10, 48'h8000}, 1'b1, 1'b0, '{32'd0, 31'd0, 1'b0}},
    '{'{2'd3, 8'd1, 8'hEF, 48'h8000}, 1'b1, 1'b0, '{32'd0, 31'd0, 1'b0}},
    // equal and backward PCR
    '{'{2'd2, 8'd128, 8'h10, 48'h8000}, 1'b1, 1'b1, '{32'd7, 31'd0, 1'b1}},
    '{'{2'd3, 8'd1, 8'h10, 48'h1}, 1'b1, 1'b1, '{32'd8, 31'd0, 1'b1}},
    // extension above 299
    '{'{2'd2, 8'd1, 8'h10, 48'h81FF}, 1'b0, 1'b0, '{32'd0, 31'd0, 1'b0}},
    // largest PCR one packet later saturates
    '{'{2'd2, 8'd1, 8'h10, 48'hFFFF_FFFF_81FF}, 1'b1, 1'b1,
      '{32'd10, tpcr_pkg::INTERVAL_MAX, 1'b0}},
    '{'{2'd3, 8'd255, 8'hFF, 48'hFFFF_FFFF_FFFF}, 1'b1, 1'b1, '{32'd11, 31'd0, 1'b1}},
    // drop back to zero: the reference is cleared
    '{'{2'd3, 8'd255, 8'hFF, 48'h0}, 1'b1, 1'b1, '{32'd12, 31'd0, 1'b1}},
    '{'{2'd2, 8'd1, 8'h10, 48'h0000_01F4_0000}, 1'b1, 1'b0, '{32'd0, 31'd0, 1'b0}},
    '{'{2'd3, 8'd255, 8'hEF, 48'hFFFF_FFFF_FFFF}, 1'b1, 1'b0, '{32'd0, 31'd0, 1'b0}},
    '{'{2'd1, 8'd255, 8'hFF, 48'h0}, 1'b1, 1'b0, '{32'd0, 31'd0, 1'b0}},
    '{'{2'd0, 8'd0, 8'h00, 48'h0}, 1'b1, 1'b0, '{32'd0, 31'd0, 1'b0}},
    '{'{2'd3, 8'd77, 8'h5A, 48'h0000_03B6_0096}, 1'b0, 1'b0, '{32'd0, 31'd0, 1'b0}},
    // ignored bits between base and extension set
    '{'{2'd2, 8'd1, 8'h10, 48'h0000_03E8_7E05}, 1'b0, 1'b0, '{32'd0, 31'd0, 1'b0}},
    '{'{2'd3, 8'd2, 8'h10, 48'h0000_03E8_0004}, 1'b1, 1'b1, '{32'd19, 31'd0, 1'b1}},
    '{'{2'd2, 8'd1, 8'h10, 48'h8000_0000_012B}, 1'b1, 1'b1,
      '{32'd20, tpcr_pkg::INTERVAL_MAX, 1'b0}}
  };

  localparam logic [tpcr_pkg::PPD_W-1:0] SIZE_PLAN [CHUNKS] =
    '{3'd1, 3'd7, 3'd0, 3'd3, 3'd5, 3'd2, 3'd4};

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       push = 1'b0;
  logic                       full;
  tpcr_pkg::in_item_t         item = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  tpcr_pkg::result_t          result;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [tpcr_pkg::PPD_W-1:0] cfg_data = '0;

  // Pinned outcome for directed beats
  logic              pin_on = 1'b0;
  logic              pin_yields = 1'b0;
  tpcr_pkg::result_t pin_seg = '0;

  // Pacing state mirrored from the block
  logic [tpcr_pkg::CNT_W-1:0] pkt_count;
  logic [tpcr_pkg::PCR_W-1:0] anchor_pcr;
  logic [tpcr_pkg::CNT_W-1:0] anchor_pkt;
  logic [tpcr_pkg::PPD_W-1:0] dg_size;

  tpcr_pkg::result_t pending_segments[$];
  tpcr_pkg::result_t seg_pred;
  tpcr_pkg::result_t seg_want;
  bit                seg_yields;
  int                miss_count = 0;

  int tx_idle_pct = 31;
  int rx_idle_pct = 56;
  int hold_trig = 0;
  int hold_seen = 0;
  int hold_left = 0;

  ts_pcr_pacing_interval DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advance the packet number and close a segment when a PCR follows a reference
  function automatic bit pace_packet(input tpcr_pkg::in_item_t p,
                                     output tpcr_pkg::result_t seg);
    logic [tpcr_pkg::PCR_W-1:0] pcr;
    logic [tpcr_pkg::CNT_W-1:0] gap;
    longint unsigned            base;
    longint unsigned            dpcr;
    longint unsigned            span;
    seg = '0;
    pkt_count = pkt_count + 1'b1;
    if (!(p.adaptation_control == tpcr_pkg::AFC_ADAPT_ONLY ||
          p.adaptation_control == tpcr_pkg::AFC_ADAPT_PAYLOAD)
        || p.adaptation_length == 8'd0 || !p.adaptation_flags[tpcr_pkg::PCR_FLAG_BIT])
      return 1'b0;
    base = p.pcr_bytes[47:15];
    pcr = tpcr_pkg::PCR_W'(base * 300 + p.pcr_bytes[8:0]);
    if (anchor_pcr == '0) begin
      anchor_pcr = pcr;
      anchor_pkt = pkt_count;
      return 1'b0;
    end
    seg.segment_end_packet = tpcr_pkg::SEG_W'(pkt_count);
    if (pcr <= anchor_pcr) begin
      seg.pcr_not_forward = 1'b1;
    end else begin
      gap = pkt_count - anchor_pkt;
      if (gap == '0) begin
        seg.datagram_interval_us = tpcr_pkg::INTERVAL_MAX;
      end else begin
        dpcr = pcr - anchor_pcr;
        span = (dpcr * dg_size) / 27;
        span = span / gap;
        seg.datagram_interval_us = (span > tpcr_pkg::INTERVAL_MAX) ?
                                   tpcr_pkg::INTERVAL_MAX : tpcr_pkg::IV_W'(span);
      end
    end
    anchor_pcr = pcr;
    anchor_pkt = pkt_count;
    return 1'b1;
  endfunction

  // Predict on each input beat, check each result beat against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      pkt_count = '0;
      anchor_pcr = '0;
      anchor_pkt = '0;
      dg_size = tpcr_pkg::PPD_RESET;
    end else begin
      if (cfg_valid && cfg_ready)
        dg_size = cfg_data;
      if (push && !full) begin
        seg_yields = pace_packet(item, seg_pred);
        if (pin_on) begin
          seg_yields = pin_yields;
          seg_pred = pin_seg;
        end
        if (seg_yields)
          pending_segments.insert(pending_segments.size(), seg_pred);
      end
      if (pop && !empty) begin
        if (pending_segments.size() == 0) begin
          miss_count++;
          if (miss_count <= 10)
            $display("unexpected segment result: pkt %0d interval %0d not_fwd %0d",
                     result.segment_end_packet, result.datagram_interval_us,
                     result.pcr_not_forward);
        end else begin
          seg_want = pending_segments.pop_front();
          if (result.segment_end_packet !== seg_want.segment_end_packet ||
              result.datagram_interval_us !== seg_want.datagram_interval_us ||
              result.pcr_not_forward !== seg_want.pcr_not_forward) begin
            miss_count++;
            if (miss_count <= 10)
              $display("segment mismatch (exp/got): pkt %0d/%0d interval %0d/%0d nf %0d/%0d",
                       seg_want.segment_end_packet, result.segment_end_packet,
                       seg_want.datagram_interval_us, result.datagram_interval_us,
                       seg_want.pcr_not_forward, result.pcr_not_forward);
          end
        end
      end
    end
  end

  // Receiver: random pops, or hold off for a fixed stretch when asked
  always begin
    @(negedge clk);
    if (hold_seen != hold_trig) begin
      hold_seen = hold_trig;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop = 1'b0;
    end else begin
      pop = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one beat after random gaps and hold it until taken
  task automatic offer(input tpcr_pkg::in_item_t p, input bit pinned, input bit yields,
                       input tpcr_pkg::result_t outcome);
    while ($urandom_range(99) < tx_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    item = p;
    pin_on = pinned;
    pin_yields = yields;
    pin_seg = outcome;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Stop sending, wait for every segment result, then let the pipeline go quiet
  task automatic settle();
    int guard;
    guard = 0;
    push = 1'b0;
    pin_on = 1'b0;
    while (pending_segments.size() != 0 && guard < DRAIN_GUARD) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_datagram_size(input logic [tpcr_pkg::PPD_W-1:0] n);
    cfg_valid = 1'b1;
    cfg_data = n;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    tpcr_pkg::in_item_t pk;
    longint unsigned    stream_pcr;
    longint unsigned    base;
    longint unsigned    ext;
    int                 pick;
    stream_pcr = 64'd1000;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Walk the directed table at the reset datagram size
    for (int i = 0; i < $size(DIRECTED); i++)
      offer(DIRECTED[i].pkt, DIRECTED[i].pinned, DIRECTED[i].yields, DIRECTED[i].outcome);
    settle();

    for (int c = 0; c < CHUNKS; c++) begin
      write_datagram_size((c == CHUNKS - 1) ? 3'($urandom_range(7)) : SIZE_PLAN[c]);
      tx_idle_pct = (c < 3) ? 31 : (c < 5) ? 56 : 0;
      rx_idle_pct = (c < 3) ? 56 : (c < 5) ? 31 : 0;
      // Stall the receiver while a burst of PCR packets fills the block
      if (c == 5)
        hold_trig++;
      for (int k = 0; k < CHUNK_ITEMS; k++) begin
        pick = (c == 5 && k < BURST_ITEMS) ? 0 : $urandom_range(99);
        if (pick < 55) begin
          // Well-formed PCR packet on a mostly advancing clock
          pk.adaptation_control = {1'b1, 1'($urandom)};
          pk.adaptation_length = 8'($urandom_range(1, 255));
          pk.adaptation_flags = 8'($urandom) | 8'h10;
          pick = $urandom_range(99);
          if (pick < 80)
            stream_pcr += $urandom_range(1, 1 << $urandom_range(4, 26));
          else if (pick < 88)
            stream_pcr = (stream_pcr > 1000) ? stream_pcr - $urandom_range(0, 1000)
                                             : stream_pcr;
          else if (pick < 92)
            stream_pcr = 0;
          else if (pick < 96)
            stream_pcr += {$urandom, $urandom} & ((64'd1 << 41) - 1);
          if (stream_pcr > PCR_CEILING)
            stream_pcr = $urandom;
          base = stream_pcr / 300;
          ext = stream_pcr % 300;
          if ($urandom_range(4) == 0 && base != 0 && ext < 212) begin
            base--;
            ext += 300;
          end
          pk.pcr_bytes = {base[32:0], 6'($urandom), ext[8:0]};
          if (pick >= 96)
            pk.pcr_bytes = 48'({$urandom, $urandom});
        end else begin
          // Random header, mostly broken in one of the three PCR conditions
          pk.adaptation_control = 2'($urandom);
          pk.adaptation_length = 8'($urandom);
          pk.adaptation_flags = 8'($urandom);
          pk.pcr_bytes = 48'({$urandom, $urandom});
          case ($urandom_range(3))
            0: pk.adaptation_control[1] = 1'b0;
            1: pk.adaptation_length = 8'd0;
            2: pk.adaptation_flags[tpcr_pkg::PCR_FLAG_BIT] = 1'b0;
            default: ;
          endcase
        end
        offer(pk, 1'b0, 1'b0, '0);
      end
      settle();
    end

    if (pending_segments.size() != 0)
      $display("%0d segment results never arrived", pending_segments.size());
    if (miss_count == 0 && pending_segments.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
